// ----- rtl/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache and responder block: item
// structs, controller command and status structs, opcodes, event codes and
// register decode.
// ----------------------------------------------------------------------------
package arpc_pkg;

	// register port
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 64;
	localparam int REG_SEL_BIT = 3;
	localparam logic REG_OWN_IP  = 1'b0;
	localparam logic REG_OWN_MAC = 1'b1;

	// item modes
	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_PACKET = 1'b1;

	// arp opcodes
	localparam logic OP_REQUEST = 1'b0;
	localparam logic OP_REPLY   = 1'b1;

	// event codes
	localparam logic [2:0] EV_HIT           = 3'd0;
	localparam logic [2:0] EV_REQ_SENT      = 3'd1;
	localparam logic [2:0] EV_REPLY_LEARNED = 3'd2;
	localparam logic [2:0] EV_REQ_DROPPED   = 3'd3;
	localparam logic [2:0] EV_REPLY_SENT    = 3'd4;

	localparam logic [47:0] BROADCAST_MAC = 48'hFFFF_FFFF_FFFF;

	// input item
	typedef struct packed {
		logic        mode;
		logic [31:0] query_ip;
		logic        pkt_opcode;
		logic [31:0] pkt_sender_ip;
		logic [47:0] pkt_sender_mac;
		logic [31:0] pkt_target_ip;
	} arpc_in_t;

	// result item
	typedef struct packed {
		logic        send_packet;
		logic        out_opcode;
		logic [31:0] out_sender_ip;
		logic [47:0] out_sender_mac;
		logic [31:0] out_target_ip;
		logic [47:0] out_target_mac;
		logic        cache_hit;
		logic [2:0]  event_res;
	} arpc_out_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic issue;
		logic commit;
	} arpc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
		logic out_free;
	} arpc_sts_t;

endpackage

// ----- rtl/arpc_regs.sv -----
// ----------------------------------------------------------------------------
// arpc_regs
// Configuration registers behind the APB-style port: own IP at byte address
// 0, own MAC at byte address 8. Low address bits select a byte within the
// slot and are not decoded.
// ----------------------------------------------------------------------------
module arpc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [arpc_pkg::ADDR_W-1:0]  paddr,
	input  logic [arpc_pkg::DATA_W-1:0]  pwdata,
	output logic [arpc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	output logic [31:0]                  own_ip,
	output logic [47:0]                  own_mac
);
	import arpc_pkg::*;

	logic        wr_en;
	logic        reg_sel;
	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_sel = paddr[REG_SEL_BIT];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (wr_en) begin
			if (reg_sel == REG_OWN_IP) begin
				own_ip_q <= pwdata[31:0];
			end else begin
				own_mac_q <= pwdata[47:0];
			end
		end
	end

	// read mux
	always_comb begin
		if (reg_sel == REG_OWN_MAC) begin
			prdata = {16'b0, own_mac_q};
		end else begin
			prdata = {32'b0, own_ip_q};
		end
	end

	assign own_ip  = own_ip_q;
	assign own_mac = own_mac_q;

endmodule

// ----- rtl/arpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer: takes an item, runs the cache scan until a match or the last
// entry, then commits (learning a packet's sender) and loads the result register.
// ----------------------------------------------------------------------------
module arpc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	output arpc_pkg::arpc_cmd_t  cmd,
	input  arpc_pkg::arpc_sts_t  sts
);
	import arpc_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_COMMIT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// next state and commands
	always_comb begin
		state_nxt  = state_q;
		req_ready  = 1'b0;
		cmd.start  = 1'b0;
		cmd.issue  = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.scan_done) begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// checks
	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("result committed over an untaken result");

	a_accept_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> (state_q == ST_SCAN))
		else $error("accepted item did not start a scan");

endmodule

// ----- rtl/arpc_dp.sv -----
// ----------------------------------------------------------------------------
// arpc_dp
// Datapath: item register, cache tag memory with valid bits, one-entry-per-
// cycle match and free-slot scan, round-robin replacement and the result
// register.
// ----------------------------------------------------------------------------
module arpc_dp #(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  arpc_pkg::arpc_cmd_t  cmd,
	output arpc_pkg::arpc_sts_t  sts,
	input  arpc_pkg::arpc_in_t   req,
	input  logic [31:0]          own_ip,
	input  logic [47:0]          own_mac,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output arpc_pkg::arpc_out_t  rsp
);
	import arpc_pkg::*;

	localparam int IDXW = $clog2(CACHE_ENTRIES);
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(CACHE_ENTRIES - 1);

	arpc_in_t  item_q;
	logic [31:0] key;

	// tag memory and valid bits
	logic [31:0]              entry_ip_mem [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] valid_q;

	// scan pipeline
	logic [IDXW-1:0] iss_q;
	logic            live_s1;
	logic [IDXW-1:0] idx_s1;
	logic            valid_s1;
	logic [31:0]     ip_s1;
	logic            hit_now;

	// scan findings
	logic            found_q;
	logic [IDXW-1:0] found_idx_q;
	logic            free_q;
	logic [IDXW-1:0] free_idx_q;

	// replacement and commit
	logic [IDXW-1:0] rp_q;
	logic [IDXW-1:0] slot;
	logic            learn;
	logic            rsp_valid_q;
	arpc_out_t       rsp_q;
	arpc_out_t       rsp_nxt;

	// item register
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			item_q <= req;
		end
	end

	assign key   = (item_q.mode == MODE_PACKET) ? item_q.pkt_sender_ip : item_q.query_ip;
	assign learn = cmd.commit & (item_q.mode == MODE_PACKET);
	assign slot  = found_q ? found_idx_q : (free_q ? free_idx_q : rp_q);

	// tag memory: registered read for the scan, write on learn
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			ip_s1    <= entry_ip_mem[iss_q];
			valid_s1 <= valid_q[iss_q];
			idx_s1   <= iss_q;
		end
		if (learn) begin
			entry_ip_mem[slot] <= key;
		end
	end

	// compare stage
	assign hit_now       = live_s1 & valid_s1 & (ip_s1 == key);
	assign sts.scan_done = live_s1 & (hit_now | (idx_s1 == LAST_IDX));
	assign sts.out_free  = ~rsp_valid_q | rsp_ready;

	// scan address, findings, valid bits and replacement pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q       <= '0;
			live_s1     <= 1'b0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			free_q      <= 1'b0;
			free_idx_q  <= '0;
			valid_q     <= '0;
			rp_q        <= '0;
		end else begin
			live_s1 <= cmd.issue;
			if (cmd.start) begin
				iss_q   <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (cmd.issue) begin
				if (iss_q != LAST_IDX) begin
					iss_q <= iss_q + 1'b1;
				end
				if (hit_now && !found_q) begin
					found_q     <= 1'b1;
					found_idx_q <= idx_s1;
				end
				if (live_s1 && !valid_s1 && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end
			if (learn) begin
				valid_q[slot] <= 1'b1;
				if (!found_q && !free_q) begin
					rp_q <= (rp_q == LAST_IDX) ? '0 : rp_q + 1'b1;
				end
			end
		end
	end

	// result formation
	always_comb begin
		rsp_nxt = '0;
		if (item_q.mode == MODE_LOOKUP) begin
			if (found_q) begin
				rsp_nxt.cache_hit = 1'b1;
				rsp_nxt.event_res = EV_HIT;
			end else begin
				rsp_nxt.send_packet    = 1'b1;
				rsp_nxt.out_opcode     = OP_REQUEST;
				rsp_nxt.out_sender_ip  = own_ip;
				rsp_nxt.out_sender_mac = own_mac;
				rsp_nxt.out_target_ip  = item_q.query_ip;
				rsp_nxt.out_target_mac = BROADCAST_MAC;
				rsp_nxt.event_res      = EV_REQ_SENT;
			end
		end else if (item_q.pkt_opcode == OP_REPLY) begin
			rsp_nxt.event_res = EV_REPLY_LEARNED;
		end else if (item_q.pkt_target_ip == own_ip) begin
			rsp_nxt.send_packet    = 1'b1;
			rsp_nxt.out_opcode     = OP_REPLY;
			rsp_nxt.out_sender_ip  = own_ip;
			rsp_nxt.out_sender_mac = own_mac;
			rsp_nxt.out_target_ip  = item_q.pkt_sender_ip;
			rsp_nxt.out_target_mac = item_q.pkt_sender_mac;
			rsp_nxt.event_res      = EV_REPLY_SENT;
		end else begin
			rsp_nxt.event_res = EV_REQ_DROPPED;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_learn_valid: assert property (@(posedge clk) disable iff (!arst_n)
		learn |=> valid_q[$past(slot)])
		else $error("learned entry not marked valid");

	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(learn && !found_q && !free_q) |-> (&valid_q))
		else $error("entry replaced while a free entry exists");

	a_rp_range: assert property (@(posedge clk) disable iff (!arst_n)
		rp_q <= LAST_IDX)
		else $error("replacement pointer out of range");

endmodule

// ----- rtl/arp_endpoint_cache_responder_core.sv -----
// ----------------------------------------------------------------------------
// arp_endpoint_cache_responder_core
// ARP endpoint with a bounded IP-to-MAC cache: answers lookups, sends
// broadcast requests on a miss, learns from every received packet and
// replies to requests for its own address.
// ----------------------------------------------------------------------------
// One item is handled at a time. After an item is accepted the cache is
// scanned one entry per clock through the tag memory read port, stopping at
// the first matching entry, then the commit step learns the sender of a
// packet and loads the result register once the output register is free; the
// next item is accepted after that. A waiting result does not stop the next
// item being taken and scanned. Valid bits reset at once, so no clearing pass
// follows reset. Own IP sits at byte address 0 and own MAC at byte address 8;
// write them only while the block is idle.
module arp_endpoint_cache_responder_core #(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  arpc_pkg::arpc_in_t           req,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output arpc_pkg::arpc_out_t          rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [arpc_pkg::ADDR_W-1:0]  paddr,
	input  logic [arpc_pkg::DATA_W-1:0]  pwdata,
	output logic [arpc_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import arpc_pkg::*;

	arpc_cmd_t   cmd;
	arpc_sts_t   sts;
	logic [31:0] own_ip;
	logic [47:0] own_mac;

	// configuration registers
	arpc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.own_ip  (own_ip),
		.own_mac (own_mac)
	);

	// sequencer
	arpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// cache and result datapath
	arpc_dp #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.own_ip    (own_ip),
		.own_mac   (own_mac),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
